// ===== hdl/mkd_pkg.sv =====
// mkd_pkg: shared widths, register indexes, reset values and types for the
// multi-key debounce block; no dependencies
package mkd_pkg;

    localparam int PHYS_KEYS  = 4;
    localparam int HOLD_W     = 16;
    localparam int WIN_W      = 8;
    localparam int STEP_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE = 3'd6;

    // reset values
    localparam logic [HOLD_W-1:0] THRESHOLD_0_RST = 16'd1000;
    localparam logic [HOLD_W-1:0] THRESHOLD_1_RST = 16'd2000;
    localparam logic [HOLD_W-1:0] THRESHOLD_2_RST = 16'd3000;
    localparam logic [HOLD_W-1:0] THRESHOLD_3_RST = 16'd4000;
    localparam logic [WIN_W-1:0]  LONG_WINDOW_RST = 8'd20;
    localparam logic [STEP_W-1:0] HOLD_STEP_RST   = 8'd4;
    localparam logic              LONG_ENABLE_RST = 1'b1;

    typedef struct packed {
        logic [HOLD_W-1:0] threshold;
        logic [WIN_W-1:0]  window;
        logic [STEP_W-1:0] hold_step;
        logic              enable;
    } key_cfg_t;

    typedef struct packed {
        logic click;
        logic long_press;
        logic pressed;
    } key_res_t;

endpackage

// ===== hdl/mkd_key.sv =====
// mkd_key: per-key sample history, debounced level and hold timer
// depends on mkd_pkg
module mkd_key
    import mkd_pkg::*;
#(
    parameter int HISTORY_BITS = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  logic     level,
    input  key_cfg_t cfg,
    output key_res_t res
);

    logic [HISTORY_BITS-1:0] history_reg;
    logic [HISTORY_BITS-1:0] history_next;
    logic                    debounced_reg;
    logic                    debounced_next;
    logic [HOLD_W-1:0]       hold_reg;
    logic [HOLD_W-1:0]       hold_next;
    logic [HOLD_W:0]         hold_sum;
    logic [HOLD_W:0]         long_limit;

    always_comb
    begin
        history_next   = {history_reg[HISTORY_BITS-2:0], level};
        debounced_next = debounced_reg;
        hold_next      = hold_reg;
        hold_sum       = {1'b0, hold_reg} + {{(HOLD_W+1-STEP_W){1'b0}}, cfg.hold_step};
        long_limit     = {1'b0, cfg.threshold} + {{(HOLD_W+1-WIN_W){1'b0}}, cfg.window};
        if (history_next == '0)
        begin
            debounced_next = 1'b0;
            hold_next      = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];
        end
        else if (history_next == '1)
        begin
            debounced_next = 1'b1;
        end
        else
        begin
            hold_next = '0;
        end
        // previous level always equals the debounced level left by the last item
        res.click      = !debounced_reg && debounced_next;
        res.long_press = cfg.enable && (hold_next != '0) && (hold_next >= cfg.threshold)
                         && ({1'b0, hold_next} <= long_limit);
        res.pressed    = !debounced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg   <= '1;
            debounced_reg <= 1'b1;
            hold_reg      <= '0;
        end
        else if (step)
        begin
            history_reg   <= history_next;
            debounced_reg <= debounced_next;
            hold_reg      <= hold_next;
        end
    end

endmodule

// ===== hdl/multi_key_debounce_long_press.sv =====
// multi_key_debounce_long_press: top level with stream ports, register file
// and result register; depends on mkd_pkg and mkd_key
//
// One scan tick per item, one item per clock cycle sustained while
// m_axis_tready holds. An accepted item waits in the input register until
// the result register can take it; then each key unit updates its history,
// debounced level and hold timer and the masks are loaded into the result
// register together. The input register also absorbs one item while the
// result waits downstream. Keys at or above NUM_KEYS report zero in every mask.
module multi_key_debounce_long_press
    import mkd_pkg::*;
#(
    parameter int NUM_KEYS     = 4,
    parameter int HISTORY_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key0_level, key1_level, key2_level, wake_level, zero padding
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // click_mask[3:0], long_mask[7:4], stable_pressed_mask[11:8], zero padding
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ACTIVE_KEYS = (NUM_KEYS < PHYS_KEYS) ? NUM_KEYS : PHYS_KEYS;
    localparam logic [PHYS_KEYS-1:0] ACTIVE_MASK = PHYS_KEYS'((1 << ACTIVE_KEYS) - 1);

    logic [HOLD_W-1:0]    threshold_reg [PHYS_KEYS];
    logic [WIN_W-1:0]     long_window_reg;
    logic [STEP_W-1:0]    hold_step_reg;
    logic                 long_enable_reg;

    logic                 in_valid_reg;
    logic [PHYS_KEYS-1:0] in_level_reg;
    logic                 out_valid_reg;
    logic [PHYS_KEYS-1:0] click_reg;
    logic [PHYS_KEYS-1:0] long_reg;
    logic [PHYS_KEYS-1:0] pressed_reg;

    logic                 advance;
    logic                 step;
    logic [PHYS_KEYS-1:0] key_level;
    key_res_t             key_res [PHYS_KEYS];

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-3*PHYS_KEYS){1'b0}}, pressed_reg, long_reg, click_reg};

    // wake key is active high, the others active low
    assign key_level = {~in_level_reg[3], in_level_reg[2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg[0] <= THRESHOLD_0_RST;
            threshold_reg[1] <= THRESHOLD_1_RST;
            threshold_reg[2] <= THRESHOLD_2_RST;
            threshold_reg[3] <= THRESHOLD_3_RST;
            long_window_reg  <= LONG_WINDOW_RST;
            hold_step_reg    <= HOLD_STEP_RST;
            long_enable_reg  <= LONG_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD_0: threshold_reg[0] <= cfg_data[HOLD_W-1:0];
                REG_THRESHOLD_1: threshold_reg[1] <= cfg_data[HOLD_W-1:0];
                REG_THRESHOLD_2: threshold_reg[2] <= cfg_data[HOLD_W-1:0];
                REG_THRESHOLD_3: threshold_reg[3] <= cfg_data[HOLD_W-1:0];
                REG_LONG_WINDOW: long_window_reg  <= cfg_data[WIN_W-1:0];
                REG_HOLD_STEP:   hold_step_reg    <= cfg_data[STEP_W-1:0];
                REG_LONG_ENABLE: long_enable_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_level_reg <= s_axis_tdata[PHYS_KEYS-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < PHYS_KEYS; k++)
        begin : g_key
            if (k < NUM_KEYS)
            begin : g_on
                key_cfg_t key_cfg;

                assign key_cfg.threshold = threshold_reg[k];
                assign key_cfg.window    = long_window_reg;
                assign key_cfg.hold_step = hold_step_reg;
                assign key_cfg.enable    = long_enable_reg;

                mkd_key #(
                    .HISTORY_BITS (HISTORY_BITS)
                ) u_key (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .step  (step),
                    .level (key_level[k]),
                    .cfg   (key_cfg),
                    .res   (key_res[k])
                );
            end
            else
            begin : g_off
                assign key_res[k] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < PHYS_KEYS; i++)
            begin
                click_reg[i]   <= key_res[i].click;
                long_reg[i]    <= key_res[i].long_press;
                pressed_reg[i] <= key_res[i].pressed;
            end
        end
    end

    a_click_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((click_reg & pressed_reg) == '0))
        else $error("click reported on a key that is still pressed");

    a_absent_keys_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((click_reg | long_reg | pressed_reg) & ~ACTIVE_MASK) == '0))
        else $error("absent key shows activity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("waiting item dropped from input register");

    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!in_valid_reg || !out_valid_reg || m_axis_tready))
        else $error("ready raised with both registers full and stalled");

endmodule
